// ===== rtl/vgee_pkg.sv =====
// Package: constants, types and command/status structs for the visibility graph edge engine
`timescale 1ns / 1ps
package vgee_pkg;
  localparam int MaxSpots    = 64;
  localparam int MaxBarriers = 256;
  localparam int SpotAw      = $clog2(MaxSpots);
  localparam int BarAw       = $clog2(MaxBarriers);
  localparam int CoordW      = 12;
  localparam int DistW       = 21;

  localparam logic [1:0] KIND_ADD_SPOT    = 2'd0;
  localparam logic [1:0] KIND_ADD_BARRIER = 2'd1;
  localparam logic [1:0] KIND_QUERY       = 2'd2;
  localparam logic [1:0] KIND_CLEAR       = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_LINK  = 2'd1;
  localparam logic [1:0] ST_UNLOADED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } pt_t;

  // controller -> datapath commands
  typedef struct packed {
    logic cap_req;      // capture the request fields
    logic spot_wr;      // write spot at spot_count
    logic clear;        // zero both counts
    logic ld_a;         // latch spot read data as a
    logic ld_b;         // latch spot read data as b
    logic bar_rd;       // issue barrier read at index
    logic idx_zero;     // index <= 0
    logic idx_inc;      // index <= index + 1
    logic prev_ld;      // prev <= barrier read data
    logic carry_init;   // prev <= request point (insert carry)
    logic seg_eval;     // evaluate crossing of prev/read data
    logic ins_wr;       // store[index] <= prev
    logic bcnt_inc;     // barrier_count + 1
    logic sqrt_start;   // start root
    logic sqrt_step;    // one root iteration
    logic res_ld;       // load result register
    logic [1:0] res_status;
    logic res_dist;     // take root as distance
    logic spot_to;      // read to-spot instead of from-spot
  } vgee_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] kind;
    logic spot_full;
    logic bar_full;
    logic idx_bad;
    logic same_idx;
    logic idx_lt_cnt;   // index < barrier_count
    logic rd_lt_p;      // read data < request point
    logic rd_eq_p;
    logic idx_is_zero;
    logic hit;          // crossing found
    logic sqrt_done;
  } vgee_sts_t;
endpackage

// ===== rtl/vgee_if.sv =====
// Valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps
interface vgee_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic signed [vgee_pkg::CoordW-1:0] x_coord;
  logic signed [vgee_pkg::CoordW-1:0] y_coord;
  logic [5:0]                    from_spot;
  logic [5:0]                    to_spot;
  modport source (output valid, kind, x_coord, y_coord, from_spot, to_spot, input ready);
  modport sink   (input valid, kind, x_coord, y_coord, from_spot, to_spot, output ready);
endinterface

interface vgee_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [vgee_pkg::DistW-1:0]    distance_q8;
  modport source (output valid, status, distance_q8, input ready);
  modport sink   (input valid, status, distance_q8, output ready);
endinterface

// ===== rtl/visibility_graph_edge_engine_top.sv =====
// Top level: visibility graph edge engine, controller plus datapath
// Add spot, clear, unloaded or same-index query go straight to the result; add barrier
// searches the sorted store for its place and ripples later entries up; query scans the
// barriers (read, then evaluate) until a crossing, then takes 22 root steps and a done state.
// One request in flight; the next request can be taken in the cycle after the result handshake.
// Reset (rst_n, synchronous, low) empties both stores; stored points are undefined.
`timescale 1ns / 1ps
module visibility_graph_edge_engine_top (
  input  logic       clk,
  input  logic       rst_n,
  vgee_in_if.sink    in_ch,
  vgee_out_if.source out_ch
);
  vgee_pkg::vgee_cmd_t cmd;
  vgee_pkg::vgee_sts_t sts;

  vgee_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  vgee_datapath u_dp (
    .clk, .rst_n,
    .in_kind(in_ch.kind), .in_x(in_ch.x_coord), .in_y(in_ch.y_coord),
    .in_from(in_ch.from_spot), .in_to(in_ch.to_spot),
    .cmd, .sts,
    .res_status(out_ch.status), .res_dist(out_ch.distance_q8)
  );
endmodule

// ===== rtl/vgee_datapath.sv =====
// Datapath: spot and barrier memories, crossing test, square root, result register
`timescale 1ns / 1ps
module vgee_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  in_kind,
  input  logic signed [vgee_pkg::CoordW-1:0] in_x,
  input  logic signed [vgee_pkg::CoordW-1:0] in_y,
  input  logic [5:0]                  in_from,
  input  logic [5:0]                  in_to,
  input  vgee_pkg::vgee_cmd_t         cmd,
  output vgee_pkg::vgee_sts_t         sts,
  output logic [1:0]                  res_status,
  output logic [vgee_pkg::DistW-1:0]  res_dist
);
  localparam int SAW = vgee_pkg::SpotAw;
  localparam int BAW = vgee_pkg::BarAw;
  localparam int CoordW_L = vgee_pkg::CoordW + 1;

  // request capture
  logic [1:0]        kind_r;
  vgee_pkg::pt_t     p_r;
  logic [5:0]        from_r, to_r;
  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      kind_r <= in_kind;
      p_r    <= '{x: in_x, y: in_y};
      from_r <= in_from;
      to_r   <= in_to;
    end
  end

  // counts
  logic [SAW:0] spot_cnt_r;
  logic [BAW:0] bar_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      spot_cnt_r <= '0;
      bar_cnt_r  <= '0;
    end else begin
      if (cmd.spot_wr) spot_cnt_r <= spot_cnt_r + 1'b1;
      if (cmd.bcnt_inc) bar_cnt_r <= bar_cnt_r + 1'b1;
    end
  end

  // spot memory, registered read
  vgee_pkg::pt_t spot_mem [vgee_pkg::MaxSpots];
  vgee_pkg::pt_t spot_rd_r;
  logic [SAW-1:0] spot_ra;
  assign spot_ra = cmd.spot_to ? to_r[SAW-1:0] : from_r[SAW-1:0];
  always_ff @(posedge clk) begin
    if (cmd.spot_wr) spot_mem[spot_cnt_r[SAW-1:0]] <= p_r;
    spot_rd_r <= spot_mem[spot_ra];
  end

  vgee_pkg::pt_t a_r, b_r;
  always_ff @(posedge clk) begin
    if (cmd.ld_a) a_r <= spot_rd_r;
    if (cmd.ld_b) b_r <= spot_rd_r;
  end

  // barrier index
  logic [BAW:0] idx_r;
  always_ff @(posedge clk) begin
    if (cmd.idx_zero)     idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
  end

  // barrier memory: one write, one registered read; prev doubles as insert carry
  vgee_pkg::pt_t bar_mem [vgee_pkg::MaxBarriers];
  vgee_pkg::pt_t bar_rd_r, prev_r;
  always_ff @(posedge clk) begin
    if (cmd.ins_wr) bar_mem[idx_r[BAW-1:0]] <= prev_r;
    if (cmd.bar_rd) bar_rd_r <= bar_mem[idx_r[BAW-1:0]];
    if (cmd.carry_init)   prev_r <= p_r;
    else if (cmd.prev_ld) prev_r <= bar_rd_r;
  end

  // point compare of read data against request
  logic rd_lt, rd_eq;
  assign rd_eq = (bar_rd_r.x == p_r.x) && (bar_rd_r.y == p_r.y);
  assign rd_lt = (bar_rd_r.x < p_r.x) || ((bar_rd_r.x == p_r.x) && (bar_rd_r.y < p_r.y));

  // crossing test: c = prev, successor = read data
  logic signed [CoordW_L-1:0] dx1, dy1, vx, vy;
  assign dx1 = CoordW_L'(b_r.x) - CoordW_L'(a_r.x);
  assign dy1 = CoordW_L'(b_r.y) - CoordW_L'(a_r.y);
  assign vx  = CoordW_L'(prev_r.x) - CoordW_L'(a_r.x);
  assign vy  = CoordW_L'(prev_r.y) - CoordW_L'(a_r.y);
  logic vert, horz;
  assign vert = (bar_rd_r.x == prev_r.x) &&
                (CoordW_L'(bar_rd_r.y) == CoordW_L'(prev_r.y) + 13'sd1);
  assign horz = (bar_rd_r.y == prev_r.y) &&
                (CoordW_L'(bar_rd_r.x) == CoordW_L'(prev_r.x) + 13'sd1);
  // vertical: d2=(0,1): vp=dx1, n1=vx. horizontal: d2=(1,0): vp=-dy1, n1=-vy
  logic signed [27:0] vp, n1, n2;
  logic signed [26:0] m1, m2;
  assign m1 = vx * dy1;
  assign m2 = vy * dx1;
  assign n2 = 28'(m1) - 28'(m2);
  assign vp = vert ? 28'(dx1) : -28'(dy1);
  assign n1 = vert ? 28'(vx)  : -28'(vy);
  function automatic logic in_unit(input logic signed [27:0] n, input logic signed [27:0] d);
    if (d > 0) return (n >= 0) && (n <= d);
    return (n <= 0) && (n >= d);
  endfunction
  logic hit_r;
  always_ff @(posedge clk) begin
    if (cmd.idx_zero) hit_r <= 1'b0;
    else if (cmd.seg_eval && (vert || horz) && (vp != 0) && in_unit(n1, vp) && in_unit(n2, vp))
      hit_r <= 1'b1;
  end

  // bitwise integer square root of (dx^2+dy^2)<<16, two bits per step
  logic signed [25:0] sq_x, sq_y;
  assign sq_x = dx1 * dx1;
  assign sq_y = dy1 * dy1;
  logic [42:0] rem_r;
  logic [42:0] res_r;
  logic [42:0] bit_r;
  logic [42:0] trial;
  assign trial = res_r + bit_r;
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rem_r <= {27'(sq_x) + 27'(sq_y), 16'd0};
      res_r <= '0;
      bit_r <= 43'd1 << 42;
    end else if (cmd.sqrt_step && bit_r != 0) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_status <= cmd.res_status;
      res_dist   <= cmd.res_dist ? res_r[vgee_pkg::DistW-1:0] : '0;
    end
  end

  assign sts.kind        = kind_r;
  assign sts.spot_full   = spot_cnt_r >= (SAW+1)'(vgee_pkg::MaxSpots);
  assign sts.bar_full    = bar_cnt_r >= (BAW+1)'(vgee_pkg::MaxBarriers);
  assign sts.idx_bad     = ({1'b0, from_r} >= 7'(spot_cnt_r)) || ({1'b0, to_r} >= 7'(spot_cnt_r));
  assign sts.same_idx    = from_r == to_r;
  assign sts.idx_lt_cnt  = idx_r < bar_cnt_r;
  assign sts.rd_lt_p     = rd_lt;
  assign sts.rd_eq_p     = rd_eq;
  assign sts.idx_is_zero = idx_r == '0;
  assign sts.hit         = hit_r;
  assign sts.sqrt_done   = bit_r == '0;
endmodule

// ===== rtl/vgee_ctrl.sv =====
// Controller: sequences adds, sorted insertion, query scan and root per request
`timescale 1ns / 1ps
module vgee_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  vgee_pkg::vgee_sts_t sts,
  output vgee_pkg::vgee_cmd_t cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SRCH   = 4'd2;  // read issued at idx
  localparam logic [3:0] S_SRCHC  = 4'd3;  // compare read data
  localparam logic [3:0] S_SHRD   = 4'd4;  // read idx for ripple
  localparam logic [3:0] S_SHWR   = 4'd5;  // write carry at idx, carry <= old entry
  localparam logic [3:0] S_QA     = 4'd6;
  localparam logic [3:0] S_QB     = 4'd7;
  localparam logic [3:0] S_SCRD   = 4'd8;
  localparam logic [3:0] S_SCEV   = 4'd9;
  localparam logic [3:0] S_SQRT   = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
  end

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);

  always_comb begin
    cmd = '0;
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_valid) begin
        cmd.cap_req = 1'b1;
        st_nxt = S_DISP;
      end
      S_DISP: begin
        cmd.idx_zero = 1'b1;
        unique case (sts.kind)
          vgee_pkg::KIND_ADD_SPOT: begin
            cmd.res_ld = 1'b1;
            if (sts.spot_full) cmd.res_status = vgee_pkg::ST_FULL;
            else cmd.spot_wr = 1'b1;
            st_nxt = S_OUT;
          end
          vgee_pkg::KIND_ADD_BARRIER: begin
            cmd.carry_init = 1'b1;
            st_nxt = S_SRCH;
          end
          vgee_pkg::KIND_QUERY: begin
            cmd.res_ld = 1'b1;
            if (sts.idx_bad) begin
              cmd.res_status = vgee_pkg::ST_UNLOADED;
              st_nxt = S_OUT;
            end else if (sts.same_idx) begin
              cmd.res_status = vgee_pkg::ST_NO_LINK;
              st_nxt = S_OUT;
            end else begin
              st_nxt = S_QA;
            end
          end
          default: begin
            cmd.clear = 1'b1;
            cmd.res_ld = 1'b1;
            st_nxt = S_OUT;
          end
        endcase
      end
      // linear search for insert position
      S_SRCH: begin
        if (sts.idx_lt_cnt) begin
          cmd.bar_rd = 1'b1;
          st_nxt = S_SRCHC;
        end else if (sts.bar_full) begin
          cmd.res_ld = 1'b1;
          cmd.res_status = vgee_pkg::ST_FULL;
          st_nxt = S_OUT;
        end else begin
          // append past the last entry
          cmd.ins_wr = 1'b1;
          cmd.bcnt_inc = 1'b1;
          cmd.res_ld = 1'b1;
          st_nxt = S_OUT;
        end
      end
      S_SRCHC: begin
        if (sts.rd_lt_p) begin
          cmd.idx_inc = 1'b1;
          st_nxt = S_SRCH;
        end else if (sts.rd_eq_p) begin
          cmd.res_ld = 1'b1;
          st_nxt = S_OUT;
        end else if (sts.bar_full) begin
          cmd.res_ld = 1'b1;
          cmd.res_status = vgee_pkg::ST_FULL;
          st_nxt = S_OUT;
        end else begin
          // place new point, carry displaced entry upward
          cmd.ins_wr = 1'b1;
          cmd.prev_ld = 1'b1;
          cmd.idx_inc = 1'b1;
          st_nxt = S_SHRD;
        end
      end
      // ripple: read entry at idx, or drop the carry at the end
      S_SHRD: begin
        if (sts.idx_lt_cnt) begin
          cmd.bar_rd = 1'b1;
          st_nxt = S_SHWR;
        end else begin
          cmd.ins_wr = 1'b1;
          cmd.bcnt_inc = 1'b1;
          cmd.res_ld = 1'b1;
          st_nxt = S_OUT;
        end
      end
      S_SHWR: begin
        cmd.ins_wr = 1'b1;
        cmd.prev_ld = 1'b1;
        cmd.idx_inc = 1'b1;
        st_nxt = S_SHRD;
      end
      // query: fetch both spots
      S_QA: begin
        cmd.spot_to = 1'b1;
        cmd.ld_a = 1'b1;
        st_nxt = S_QB;
      end
      S_QB: begin
        cmd.ld_b = 1'b1;
        cmd.idx_zero = 1'b1;
        st_nxt = S_SCRD;
      end
      S_SCRD: begin
        if (sts.hit) begin
          cmd.res_ld = 1'b1;
          cmd.res_status = vgee_pkg::ST_NO_LINK;
          st_nxt = S_OUT;
        end else if (sts.idx_lt_cnt) begin
          cmd.bar_rd = 1'b1;
          st_nxt = S_SCEV;
        end else begin
          cmd.sqrt_start = 1'b1;
          st_nxt = S_SQRT;
        end
      end
      S_SCEV: begin
        if (!sts.idx_is_zero) cmd.seg_eval = 1'b1;
        cmd.prev_ld = 1'b1;
        cmd.idx_inc = 1'b1;
        st_nxt = S_SCRD;
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.res_ld = 1'b1;
          cmd.res_dist = 1'b1;
          st_nxt = S_OUT;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/vgee_checker.sv =====
// Port-level checker for the edge engine, bound to the top level
`timescale 1ns / 1ps
module vgee_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [20:0] out_dist
);
  // one request at a time: no accept while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("input ready while result pending");
  // distance only on linked results
  a_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != vgee_pkg::ST_OK |-> out_dist == '0)
    else $error("distance on non-linked result");
  // accepted request never yields a result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");
  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
endmodule

bind visibility_graph_edge_engine_top vgee_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_dist(out_ch.distance_q8)
);
